// File: hw/rtl/ofl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofl_pkg: shared types and constants of the face line parser
// Result record, result kinds, parse phases and byte classifiers.
// ----------------------------------------------------------------------------
package ofl_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

    // Result kinds.
    localparam logic [2:0] K_POINT    = 3'd0;
    localparam logic [2:0] K_FINISH   = 3'd1;
    localparam logic [2:0] K_EXPECT   = 3'd2;
    localparam logic [2:0] K_TOOMANY  = 3'd3;
    localparam logic [2:0] K_OVERFLOW = 3'd4;

    // Parse phases.
    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_V_NUM   = 4'd1;
    localparam logic [3:0] PH_V_AFTER = 4'd2;
    localparam logic [3:0] PH_SLASH1  = 4'd3;
    localparam logic [3:0] PH_SLASH2  = 4'd4;
    localparam logic [3:0] PH_T_NUM   = 4'd5;
    localparam logic [3:0] PH_T_AFTER = 4'd6;
    localparam logic [3:0] PH_SLASH3  = 4'd7;
    localparam logic [3:0] PH_N_NUM   = 4'd8;

    localparam logic [7:0]  CHAR_SLASH = 8'h2F;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [31:0] INDEX_ONE  = 32'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] vertex;
        logic [31:0] texture;
        logic [31:0] normal;
        logic [3:0]  pnum;
        logic [4:0]  pcnt;
        logic        last;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    // Finish or error record: no point data, only the count.
    function automatic result_t make_end(input logic [2:0] kind, input logic [4:0] pcnt);
        result_t r;
        r         = '0;
        r.kind    = kind;
        r.pcnt    = pcnt;
        r.last    = 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ofl_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofl_core: face line parse state and result generation
// Updates the parse phase and index accumulators for one byte per cycle while in_valid is high, and
// produces up to two result records for each accepted beat.
// ----------------------------------------------------------------------------
module ofl_core #(
    parameter int MAX_POINTS = ofl_pkg::MAX_POINTS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire logic [7:0]      in_char,
    input  wire logic            in_end,
    output logic [1:0]           push_cnt,
    output ofl_pkg::result_t     res0,
    output ofl_pkg::result_t     res1
);
    import ofl_pkg::*;

    localparam int PW = $clog2(MAX_POINTS + 1);

    logic [3:0]    phase_reg, phase_next;
    logic [31:0]   vacc_reg, vacc_next;
    logic [31:0]   tacc_reg, tacc_next;
    logic [31:0]   nacc_reg, nacc_next;
    logic [PW-1:0] pts_reg, pts_next;
    logic          drain_reg, drain_next;

    logic [PW-1:0] pts_inc;
    logic [PW-1:0] pts_cur;
    logic [3:0]    digit;
    logic [31:0]   acc_sel;
    logic [35:0]   acc_prod;
    logic          acc_ovf;
    logic          c_ws, c_dig, c_slash;
    logic          emit, begin_pt, do_fail;
    logic [2:0]    fail_kind;
    result_t       point_res;

    // Decimal accumulate as acc*8 + acc*2 + digit, overflow in the top bits.
    assign digit    = 4'(in_char - CHAR_ZERO);
    assign acc_sel  = (phase_reg == PH_V_NUM) ? vacc_reg :
                      (phase_reg == PH_T_NUM) ? tacc_reg : nacc_reg;
    assign acc_prod = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} + 36'(digit);
    assign acc_ovf  = |acc_prod[35:32];

    assign c_ws    = is_ws(in_char);
    assign c_dig   = is_digit(in_char);
    assign c_slash = (in_char == CHAR_SLASH);
    assign pts_inc = pts_reg + PW'(1);

    // Record for the point currently held in the accumulators.
    always_comb begin
        point_res         = '0;
        point_res.kind    = K_POINT;
        point_res.vertex  = vacc_reg;
        point_res.texture = tacc_reg;
        point_res.normal  = nacc_reg;
        point_res.pnum    = 4'(pts_reg);
        point_res.pcnt    = 5'(pts_inc);
        point_res.last    = 1'b0;
    end

    // Next state and results for one beat.
    always_comb begin
        phase_next = phase_reg;
        vacc_next  = vacc_reg;
        tacc_next  = tacc_reg;
        nacc_next  = nacc_reg;
        pts_next   = pts_reg;
        drain_next = drain_reg;
        res0       = '0;
        res1       = '0;
        push_cnt   = 2'd0;
        emit       = 1'b0;
        begin_pt   = 1'b0;
        do_fail    = 1'b0;
        fail_kind  = K_EXPECT;
        pts_cur    = pts_reg;

        if (in_valid && in_end) begin
            if (!drain_reg) begin
                case (phase_reg)
                    PH_V_NUM, PH_V_AFTER, PH_T_NUM, PH_T_AFTER, PH_N_NUM: begin
                        res0     = point_res;
                        res1     = make_end(K_FINISH, 5'(pts_inc));
                        push_cnt = 2'd2;
                    end
                    PH_SLASH1, PH_SLASH2, PH_SLASH3: begin
                        res0     = make_end(K_EXPECT, 5'(pts_reg));
                        push_cnt = 2'd1;
                    end
                    default: begin
                        res0     = make_end(K_FINISH, 5'(pts_reg));
                        push_cnt = 2'd1;
                    end
                endcase
            end
            // Every line end returns the parser to its reset state.
            phase_next = PH_START;
            vacc_next  = '0;
            tacc_next  = INDEX_ONE;
            nacc_next  = INDEX_ONE;
            pts_next   = '0;
            drain_next = 1'b0;
        end else if (in_valid && !drain_reg) begin
            case (phase_reg)
                PH_V_NUM, PH_T_NUM, PH_N_NUM: begin
                    if (c_dig) begin
                        if (acc_ovf) begin
                            do_fail   = 1'b1;
                            fail_kind = K_OVERFLOW;
                        end else if (phase_reg == PH_V_NUM) begin
                            vacc_next = acc_prod[31:0];
                        end else if (phase_reg == PH_T_NUM) begin
                            tacc_next = acc_prod[31:0];
                        end else begin
                            nacc_next = acc_prod[31:0];
                        end
                    end else if (phase_reg != PH_N_NUM && c_ws) begin
                        phase_next = (phase_reg == PH_V_NUM) ? PH_V_AFTER : PH_T_AFTER;
                    end else if (phase_reg != PH_N_NUM && c_slash) begin
                        phase_next = (phase_reg == PH_V_NUM) ? PH_SLASH1 : PH_SLASH3;
                    end else begin
                        emit     = 1'b1;
                        begin_pt = 1'b1;
                    end
                end
                PH_V_AFTER, PH_T_AFTER: begin
                    if (c_ws) begin
                        phase_next = phase_reg;
                    end else if (c_slash) begin
                        phase_next = (phase_reg == PH_V_AFTER) ? PH_SLASH1 : PH_SLASH3;
                    end else begin
                        emit     = 1'b1;
                        begin_pt = 1'b1;
                    end
                end
                PH_SLASH1: begin
                    if (c_ws) begin
                        phase_next = phase_reg;
                    end else if (c_slash) begin
                        tacc_next  = INDEX_ONE;
                        phase_next = PH_SLASH2;
                    end else if (c_dig) begin
                        tacc_next  = 32'(digit);
                        phase_next = PH_T_NUM;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_SLASH2, PH_SLASH3: begin
                    if (c_ws) begin
                        phase_next = phase_reg;
                    end else if (c_dig) begin
                        nacc_next  = 32'(digit);
                        phase_next = PH_N_NUM;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                default: begin
                    begin_pt = 1'b1;
                end
            endcase

            // A finished point goes out before anything the same byte causes.
            if (emit) begin
                res0       = point_res;
                push_cnt   = 2'd1;
                pts_next   = pts_inc;
                pts_cur    = pts_inc;
                phase_next = PH_START;
            end

            // The byte may open a new point.
            if (begin_pt) begin
                phase_next = PH_START;
                if (!c_ws) begin
                    if (pts_cur >= PW'(MAX_POINTS)) begin
                        do_fail   = 1'b1;
                        fail_kind = K_TOOMANY;
                    end else if (!c_dig) begin
                        do_fail   = 1'b1;
                        fail_kind = K_EXPECT;
                    end else begin
                        vacc_next  = 32'(digit);
                        tacc_next  = INDEX_ONE;
                        nacc_next  = INDEX_ONE;
                        phase_next = PH_V_NUM;
                    end
                end
            end

            // An error ends the line; the rest is dropped until line end.
            if (do_fail) begin
                drain_next = 1'b1;
                if (emit) begin
                    res1     = make_end(fail_kind, 5'(pts_cur));
                    push_cnt = 2'd2;
                end else begin
                    res0     = make_end(fail_kind, 5'(pts_cur));
                    push_cnt = 2'd1;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            vacc_reg  <= '0;
            tacc_reg  <= INDEX_ONE;
            nacc_reg  <= INDEX_ONE;
            pts_reg   <= '0;
            drain_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            vacc_reg  <= vacc_next;
            tacc_reg  <= tacc_next;
            nacc_reg  <= nacc_next;
            pts_reg   <= pts_next;
            drain_reg <= drain_next;
        end
    end

    // The point counter never passes the limit.
    a_pts_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        pts_reg <= PW'(MAX_POINTS))
        else $error("point count above limit");

    // While draining, only a line end produces results.
    a_drain_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_reg && !in_end) |-> (push_cnt == 2'd0))
        else $error("result while draining");

    // Two results in one beat always start with a point.
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt == 2'd2) |-> (res0.kind == K_POINT && res1.last))
        else $error("bad result pair");

endmodule
`default_nettype wire

// File: hw/rtl/ofl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofl_fifo: result queue
// Takes zero, one or two result records per cycle and hands out one beat per
// cycle while m_ready is high. Ready to the parser means room for two records.
// ----------------------------------------------------------------------------
module ofl_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [1:0]       push_cnt,
    input  wire ofl_pkg::result_t res0,
    input  wire ofl_pkg::result_t res1,
    output logic                  room,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ofl_pkg::result_t      m_data
);
    import ofl_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    result_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               pop;
    logic [FIFO_AW-1:0] wr_ptr_p1;

    assign m_valid   = (cnt_reg != '0);
    assign m_data    = mem[rd_ptr_reg];
    assign room      = (cnt_reg <= CW'(FIFO_DEPTH - 2));
    assign pop       = m_valid && m_ready;
    assign wr_ptr_p1 = wr_ptr_reg + FIFO_AW'(1);

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        cnt_next    = cnt_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Record storage, first record at the write pointer.
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_p1] <= res1;
        end
    end

    // Fill count stays within the queue.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(FIFO_DEPTH))
        else $error("result queue overrun");

    // Records are only written when room was granted.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt != 2'd0) |-> room)
        else $error("push without room");

    // A beat that is held back stays in place.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(rd_ptr_reg)))
        else $error("stalled beat lost");

endmodule
`default_nettype wire

// File: hw/rtl/obj_face_line_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// A result beat is registered into the result queue when its input beat is taken and is offered on m_ from there.
// Throughput: one input beat per cycle; the parse phase and decimal accumulate are
// one register-to-register step. A line end that closes a point yields two output
// beats, and the four-entry result queue throttles s_tready when m_tready stalls.
// Reset (aresetn low, synchronous) clears the parse state and empties the queue.
// ----------------------------------------------------------------------------
// obj_face_line_parser: streaming face line index parser
// Parses v, v/t, v//n and v/t/n points one byte per beat and reports points,
// line finish and errors on the result stream.
// ----------------------------------------------------------------------------
module obj_face_line_parser #(
    parameter int MAX_POINTS = ofl_pkg::MAX_POINTS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] character
    input  wire logic         s_tlast,   // line_end
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,   // [31:0] vertex_index, [63:32] texture_index,
                                         // [95:64] normal_index, [99:96] point_number,
                                         // [104:100] point_count, [111:105] zero
    output logic [2:0]        m_tuser,   // [2:0] result_kind
    output logic              m_tlast    // last
);
    import ofl_pkg::*;

    logic    accept;
    logic    room;
    logic [1:0] push_cnt;
    result_t res0, res1;
    result_t out_rec;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    ofl_core #(
        .MAX_POINTS (MAX_POINTS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (accept),
        .in_char  (s_tdata),
        .in_end   (s_tlast),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    ofl_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1),
        .room     (room),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (out_rec)
    );

    // Output beat packing.
    assign m_tdata = {7'b0, out_rec.pcnt, out_rec.pnum, out_rec.normal,
                      out_rec.texture, out_rec.vertex};
    assign m_tuser = out_rec.kind;
    assign m_tlast = out_rec.last;

endmodule
`default_nettype wire
